@@ rtl/core/hrlp_pkg.sv @@
package hrlp_pkg;

   localparam logic [1:0] SIZE_CODE_FOUR   = 2'd3;
   localparam logic [2:0] SIZE_FOUR_BYTES  = 3'd4;
   localparam logic [1:0] TYPE_MAIN        = 2'd0;
   localparam logic [1:0] TYPE_GLOBAL      = 2'd1;
   localparam logic [3:0] TAG_REPORT_SIZE  = 4'd7;
   localparam logic [3:0] TAG_REPORT_COUNT = 4'd9;
   localparam logic [3:0] TAG_INPUT        = 4'd8;
   localparam logic [3:0] TAG_OUTPUT       = 4'd9;
   localparam logic [3:0] TAG_FEATURE      = 4'd11;
   localparam logic [1:0] KEPT_DATA_BYTES  = 2'd2;
   localparam logic [15:0] BIT_SUM_MAX     = 16'hFFFF;

   localparam int          CSR_ADDR_WIDTH  = 3;
   localparam logic        CSR_MAX_REPORT  = 1'b0;
   localparam logic        CSR_DEF_REPORT  = 1'b1;
   localparam logic [7:0]  MAX_REPORT_RESET = 8'd64;
   localparam logic [7:0]  DEF_REPORT_RESET = 8'd64;

   typedef struct packed {
      logic [2:0]  bytes_left;
      logic [1:0]  item_type;
      logic [3:0]  item_tag;
      logic [15:0] item_value;
      logic [1:0]  byte_pos;
      logic [15:0] field_size;
      logic [15:0] field_count;
      logic [15:0] bit_sum;
   } parse_state_type;

   typedef struct packed {
      logic [7:0]  report_bytes;
      logic [15:0] report_bits;
      logic        truncated;
   } result_type;

   typedef struct packed {
      logic [7:0] max_report_bytes;
      logic [7:0] default_report_bytes;
   } csr_type;

endpackage

@@ rtl/core/hrlp_req_if.sv @@
interface hrlp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] desc_byte;
   logic       last_byte;

   modport source (output valid, output desc_byte, output last_byte, input ready);
   modport sink (input valid, input desc_byte, input last_byte, output ready);
endinterface

@@ rtl/core/hrlp_rsp_if.sv @@
interface hrlp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  report_bytes;
   logic [15:0] report_bits;
   logic        truncated;

   modport source (output valid, output report_bytes, output report_bits,
                   output truncated, input ready);
   modport sink (input valid, input report_bytes, input report_bits,
                 input truncated, output ready);
endinterface

@@ rtl/core/hid_report_length_parser.sv @@
// Channel  Dir  Interface    Payload
// req_ch   in   hrlp_req_if  desc_byte[7:0], last_byte
// rsp_ch   out  hrlp_rsp_if  report_bytes[7:0], report_bits[15:0], truncated
// csr_*    in   APB          max_report_bytes (0x0), default_report_bytes (0x4)
//
// One descriptor word per cycle while no last word is blocked; a result loads
// the result register as its last word leaves the input register. The parse step
// (decode, 16x16 multiply, saturating add, round and clamp) sits between them.
// A stalled result blocks only a last word; other words keep flowing.
// Synchronous active-high reset clears parse state and valids and presets the CSRs.
module hid_report_length_parser (
   input  logic                                  clock,
   input  logic                                  reset,
   hrlp_req_if.sink                              req_ch,
   hrlp_rsp_if.source                            rsp_ch,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [hrlp_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);
   import hrlp_pkg::*;

   csr_type         csr_ff, csr_in;
   parse_state_type state_ff, state_in, state_next;
   result_type      result, result_ff, result_in;
   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff, in_byte_in;
   logic            in_last_ff, in_last_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            advance;
   logic            csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            CSR_MAX_REPORT: csr_in.max_report_bytes     = csr_pwdata[7:0];
            CSR_DEF_REPORT: csr_in.default_report_bytes = csr_pwdata[7:0];
            default:        csr_in = csr_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_MAX_REPORT: csr_prdata = {24'd0, csr_ff.max_report_bytes};
         CSR_DEF_REPORT: csr_prdata = {24'd0, csr_ff.default_report_bytes};
         default:        csr_prdata = '0;
      endcase
   end

   assign advance      = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_ch.ready) begin
         in_valid_in = req_ch.valid;
         in_byte_in  = req_ch.desc_byte;
         in_last_in  = req_ch.last_byte;
      end
   end

   hrlp_step u_step (
      .state      (state_ff),
      .desc_byte  (in_byte_ff),
      .last_byte  (in_last_ff),
      .csr        (csr_ff),
      .state_next (state_next),
      .result     (result)
   );

   assign state_in = advance ? state_next : state_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      result_in    = result_ff;
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
         result_in    = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= '{max_report_bytes: MAX_REPORT_RESET,
                           default_report_bytes: DEF_REPORT_RESET};
         state_ff     <= '0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         csr_ff       <= csr_in;
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
      result_ff  <= result_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.report_bytes = result_ff.report_bytes;
   assign rsp_ch.report_bits  = result_ff.report_bits;
   assign rsp_ch.truncated    = result_ff.truncated;

`ifndef SYNTH
   a_ready_low_holds_word: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (in_valid_ff && in_last_ff && rsp_valid_ff))
      else $error("input stalled without a blocked last word");

   a_last_makes_result: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> rsp_valid_ff)
      else $error("last word did not load a result");

   a_last_clears_state: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (state_ff == '0))
      else $error("parse state not cleared after last word");

   a_bytes_left_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.bytes_left <= SIZE_FOUR_BYTES)
      else $error("item data count out of range");

   a_zero_sum_default: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (result_ff.report_bits == 16'd0)) |->
      (result_ff.report_bytes == csr_ff.default_report_bytes))
      else $error("empty descriptor did not give default length");
`endif

endmodule

@@ rtl/core/hrlp_step.sv @@
module hrlp_step (
   input  hrlp_pkg::parse_state_type state,
   input  logic [7:0]                desc_byte,
   input  logic                      last_byte,
   input  hrlp_pkg::csr_type         csr,
   output hrlp_pkg::parse_state_type state_next,
   output hrlp_pkg::result_type      result
);
   import hrlp_pkg::*;

   parse_state_type item;
   logic            apply;
   logic [31:0]     product;
   logic [32:0]     sum_wide;
   logic [15:0]     sum_sat;
   logic [15:0]     bit_sum_new;
   logic [16:0]     round_up;
   logic [13:0]     len_full;
   logic [7:0]      len_clamped;
   logic            is_data_main;

   always_comb begin
      item = state;
      if (state.bytes_left == 3'd0) begin
         item.item_type  = desc_byte[3:2];
         item.item_tag   = desc_byte[7:4];
         item.item_value = '0;
         item.byte_pos   = '0;
         item.bytes_left = (desc_byte[1:0] == SIZE_CODE_FOUR) ? SIZE_FOUR_BYTES
                                                              : {1'b0, desc_byte[1:0]};
         apply           = (desc_byte[1:0] == 2'd0);
      end else begin
         if (state.byte_pos < KEPT_DATA_BYTES) begin
            if (state.byte_pos[0]) begin
               item.item_value[15:8] = state.item_value[15:8] | desc_byte;
            end else begin
               item.item_value[7:0] = state.item_value[7:0] | desc_byte;
            end
         end
         item.byte_pos   = state.byte_pos + 2'd1;
         item.bytes_left = state.bytes_left - 3'd1;
         apply           = (state.bytes_left == 3'd1);
      end
   end

   assign product  = state.field_size * state.field_count;
   assign sum_wide = {17'd0, state.bit_sum} + {1'b0, product};
   assign sum_sat  = (sum_wide > {17'd0, BIT_SUM_MAX}) ? BIT_SUM_MAX : sum_wide[15:0];

   assign is_data_main = (item.item_type == TYPE_MAIN) &&
                         ((item.item_tag == TAG_INPUT) || (item.item_tag == TAG_OUTPUT) ||
                          (item.item_tag == TAG_FEATURE));

   always_comb begin
      state_next = item;
      if (apply) begin
         if (item.item_type == TYPE_GLOBAL) begin
            if (item.item_tag == TAG_REPORT_SIZE) begin
               state_next.field_size = item.item_value;
            end else if (item.item_tag == TAG_REPORT_COUNT) begin
               state_next.field_count = item.item_value;
            end
         end else if (is_data_main) begin
            state_next.bit_sum = sum_sat;
         end
      end
      if (last_byte) begin
         state_next = '0;
      end
   end

   assign bit_sum_new = (apply && is_data_main) ? sum_sat : state.bit_sum;
   assign round_up    = {1'b0, bit_sum_new} + 17'd7;
   assign len_full    = round_up[16:3];
   assign len_clamped = (len_full > {6'd0, csr.max_report_bytes}) ? csr.max_report_bytes
                                                                 : len_full[7:0];

   assign result.report_bytes = (bit_sum_new == 16'd0) ? csr.default_report_bytes
                                                       : len_clamped;
   assign result.report_bits  = bit_sum_new;
   assign result.truncated    = (item.bytes_left != 3'd0);

endmodule

@@ test/hid_report_length_parser_tb.sv @@
module hid_report_length_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hrlp_pkg::*;

   localparam logic [1:0] SIZE_NONE     = 2'd0;
   localparam logic [1:0] SIZE_ONE      = 2'd1;
   localparam logic [1:0] SIZE_TWO      = 2'd2;
   localparam logic [1:0] TYPE_LOCAL    = 2'd2;
   localparam logic [1:0] TYPE_RESERVED = 2'd3;
   localparam logic [3:0] TAG_UNIT      = 4'd6;
   localparam logic [3:0] TAG_COLLECTION = 4'd10;
   localparam logic [7:0] LONG_ITEM_PREFIX = 8'hFE;

   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_MAX_REPORT = {CSR_MAX_REPORT, 2'b00};
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_DEF_REPORT = {CSR_DEF_REPORT, 2'b00};

   localparam int WATCHDOG_LIMIT = 2000;

   logic                      clock;
   logic                      reset;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [31:0]               csr_pwdata;
   logic [31:0]               csr_prdata;
   logic                      csr_pready;

   hrlp_req_if req_ch();
   hrlp_rsp_if rsp_ch();

   hid_report_length_parser uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   parse_state_type parser      = '0;
   csr_type         length_regs = '{MAX_REPORT_RESET, DEF_REPORT_RESET};
   result_type      expected_lengths[$];

   int          mismatches     = 0;
   int unsigned words_sent     = 0;
   int          stalled_cycles = 0;
   bit          req_gaps_on    = 1'b0;
   bit          rsp_stalls_on  = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int pick_delay();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
   endfunction

   function automatic int data_len(logic [7:0] hdr);
      return (hdr[1:0] == SIZE_CODE_FOUR) ? 4 : int'(hdr[1:0]);
   endfunction

   function automatic logic [1:0] rand_size_code();
      return ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 3)) : 2'($urandom_range(1, 2));
   endfunction

   task automatic flag_mismatch(input string what, input int unsigned want,
                                input int unsigned got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
   endtask

   // Advance the parse state by one descriptor word; queue a result on the last one.
   function automatic void track_descriptor_byte(logic [7:0] b, logic last);
      logic [2:0]  len;
      logic        done;
      logic [32:0] sum;
      int unsigned bytes;
      result_type  r;
      if (parser.bytes_left == 0) begin
         len = (b[1:0] == SIZE_CODE_FOUR) ? SIZE_FOUR_BYTES : {1'b0, b[1:0]};
         parser.item_type  = b[3:2];
         parser.item_tag   = b[7:4];
         parser.item_value = '0;
         parser.byte_pos   = '0;
         parser.bytes_left = len;
         done = (len == 0);
      end else begin
         if (parser.byte_pos < KEPT_DATA_BYTES)
            parser.item_value = parser.item_value | (16'(b) << (8 * parser.byte_pos));
         parser.byte_pos   = parser.byte_pos + 2'd1;
         parser.bytes_left = parser.bytes_left - 3'd1;
         done = (parser.bytes_left == 0);
      end
      if (done) begin
         if (parser.item_type == TYPE_GLOBAL && parser.item_tag == TAG_REPORT_SIZE) begin
            parser.field_size = parser.item_value;
         end else if (parser.item_type == TYPE_GLOBAL &&
                      parser.item_tag == TAG_REPORT_COUNT) begin
            parser.field_count = parser.item_value;
         end else if (parser.item_type == TYPE_MAIN &&
                      (parser.item_tag == TAG_INPUT || parser.item_tag == TAG_OUTPUT ||
                       parser.item_tag == TAG_FEATURE)) begin
            sum = 33'(parser.bit_sum) + 33'(parser.field_size) * 33'(parser.field_count);
            parser.bit_sum = (sum > 33'(BIT_SUM_MAX)) ? BIT_SUM_MAX : sum[15:0];
         end
      end
      if (last) begin
         if (parser.bit_sum == 0) begin
            r.report_bytes = length_regs.default_report_bytes;
         end else begin
            bytes = (int'(parser.bit_sum) + 7) / 8;
            r.report_bytes = (bytes > length_regs.max_report_bytes) ?
                             length_regs.max_report_bytes : 8'(bytes);
         end
         r.report_bits = parser.bit_sum;
         r.truncated   = (parser.bytes_left != 0);
         expected_lengths.push_back(r);
         parser = '0;
      end
   endfunction

   task automatic send_word(input logic [7:0] b, input logic last);
      int gap;
      gap = (req_gaps_on && $urandom_range(0, 99) < 30) ? pick_delay() : 0;
      if (gap != 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.desc_byte <= b;
      req_ch.last_byte <= last;
      do @(posedge clock); while (!req_ch.ready);
      track_descriptor_byte(b, last);
      words_sent++;
   endtask

   // Send a header and its data bytes; a cut item ends the descriptor early.
   task automatic send_item(input logic [7:0] hdr, input logic [31:0] data,
                            input bit last, input bit cut);
      int n;
      n = data_len(hdr);
      if (cut && n > 0)
         n = $urandom_range(0, n - 1);
      send_word(hdr, last && n == 0);
      for (int i = 0; i < n; i++)
         send_word(data[8*i +: 8], last && i == n - 1);
   endtask

   task automatic send_field(input logic [3:0] main_tag, input logic [15:0] size,
                             input logic [15:0] count, input bit last);
      send_item({TAG_REPORT_SIZE, TYPE_GLOBAL, SIZE_TWO}, {16'd0, size}, 1'b0, 1'b0);
      send_item({TAG_REPORT_COUNT, TYPE_GLOBAL, SIZE_TWO}, {16'd0, count}, 1'b0, 1'b0);
      send_item({main_tag, TYPE_MAIN, SIZE_NONE}, '0, last, 1'b0);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_lengths.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [CSR_ADDR_WIDTH-1:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_readback();
      logic [31:0] rd;
      csr_access(1'b0, ADDR_MAX_REPORT, '0, rd);
      if (rd !== {24'd0, length_regs.max_report_bytes})
         flag_mismatch("max_report_bytes readback", length_regs.max_report_bytes, rd);
      csr_access(1'b0, ADDR_DEF_REPORT, '0, rd);
      if (rd !== {24'd0, length_regs.default_report_bytes})
         flag_mismatch("default_report_bytes readback", length_regs.default_report_bytes, rd);
   endtask

   task automatic set_lengths(input logic [7:0] max_bytes, input logic [7:0] dflt_bytes);
      logic [31:0] rd;
      drain_results();
      csr_access(1'b1, ADDR_MAX_REPORT, {24'd0, max_bytes}, rd);
      length_regs.max_report_bytes = max_bytes;
      csr_access(1'b1, ADDR_DEF_REPORT, {24'd0, dflt_bytes}, rd);
      length_regs.default_report_bytes = dflt_bytes;
      check_readback();
   endtask

   task automatic test_reset_values();
      check_readback();
      send_word({TAG_INPUT, TYPE_MAIN, SIZE_NONE}, 1'b1);
      send_word(8'h00, 1'b1);
   endtask

   task automatic test_report_items();
      send_field(TAG_INPUT, 16'd8, 16'd3, 1'b0);
      send_item({TAG_OUTPUT, TYPE_MAIN, SIZE_ONE}, 32'h02, 1'b0, 1'b0);
      send_item({TAG_FEATURE, TYPE_MAIN, SIZE_ONE}, 32'h02, 1'b1, 1'b0);
      send_field(TAG_INPUT, 16'd1, 16'd1, 1'b1);
      // drop data beyond two bytes, ignore reserved, long, local and other tags
      send_item({TAG_REPORT_SIZE, TYPE_GLOBAL, SIZE_CODE_FOUR}, 32'hBBAA_0005, 1'b0, 1'b0);
      send_item({TAG_REPORT_COUNT, TYPE_GLOBAL, SIZE_ONE}, 32'h07, 1'b0, 1'b0);
      send_item({TAG_REPORT_SIZE, TYPE_RESERVED, SIZE_ONE}, 32'hFF, 1'b0, 1'b0);
      send_item(LONG_ITEM_PREFIX, 32'h0000_FFFF, 1'b0, 1'b0);
      send_item({TAG_REPORT_COUNT, TYPE_LOCAL, SIZE_ONE}, 32'h40, 1'b0, 1'b0);
      send_item({TAG_UNIT, TYPE_GLOBAL, SIZE_ONE}, 32'h11, 1'b0, 1'b0);
      send_item({TAG_COLLECTION, TYPE_MAIN, SIZE_ONE}, 32'h01, 1'b0, 1'b0);
      send_item({TAG_INPUT, TYPE_MAIN, SIZE_ONE}, 32'h02, 1'b1, 1'b0);
      send_field(TAG_FEATURE, 16'hFFFF, 16'hFFFF, 1'b0);
      send_item({TAG_OUTPUT, TYPE_MAIN, SIZE_NONE}, '0, 1'b1, 1'b0);
   endtask

   task automatic test_truncated_items();
      send_word({TAG_REPORT_SIZE, TYPE_GLOBAL, SIZE_TWO}, 1'b1);
      send_word({TAG_REPORT_COUNT, TYPE_GLOBAL, SIZE_CODE_FOUR}, 1'b0);
      send_word(8'hA5, 1'b0);
      send_word(8'h5A, 1'b1);
      send_field(TAG_INPUT, 16'd8, 16'd2, 1'b0);
      send_word({TAG_INPUT, TYPE_MAIN, SIZE_ONE}, 1'b1);
      send_item({TAG_REPORT_COUNT, TYPE_GLOBAL, SIZE_CODE_FOUR}, 32'hFFFF_FFFF, 1'b1, 1'b0);
   endtask

   task automatic test_register_extremes();
      set_lengths(8'd1, 8'd0);
      send_word({TAG_INPUT, TYPE_MAIN, SIZE_NONE}, 1'b1);
      send_field(TAG_INPUT, 16'd9, 16'd1, 1'b1);
      set_lengths(8'd255, 8'd255);
      send_word(8'h00, 1'b1);
      send_field(TAG_OUTPUT, 16'hFFFF, 16'hFFFF, 1'b1);
      // zero clamp
      set_lengths(8'd0, 8'd17);
      send_field(TAG_FEATURE, 16'd1, 16'd1, 1'b1);
      send_word(8'h00, 1'b1);
      set_lengths(MAX_REPORT_RESET, DEF_REPORT_RESET);
   endtask

   task automatic send_random_descriptor();
      int          n_items;
      int          kind;
      logic [7:0]  hdr;
      logic [31:0] data;
      n_items = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 10);
      for (int i = 0; i < n_items; i++) begin
         kind = $urandom_range(0, 99);
         data = $urandom;
         if (kind < 25) begin
            hdr = {TAG_REPORT_SIZE, TYPE_GLOBAL, rand_size_code()};
            if ($urandom_range(0, 7) != 0)
               data = $urandom_range(1, 32);
         end else if (kind < 50) begin
            hdr = {TAG_REPORT_COUNT, TYPE_GLOBAL, rand_size_code()};
            if ($urandom_range(0, 7) != 0)
               data = $urandom_range(1, 64);
         end else if (kind < 85) begin
            case ($urandom_range(0, 2))
               0: hdr = {TAG_INPUT, TYPE_MAIN, 2'($urandom_range(0, 1))};
               1: hdr = {TAG_OUTPUT, TYPE_MAIN, 2'($urandom_range(0, 1))};
               default: hdr = {TAG_FEATURE, TYPE_MAIN, 2'($urandom_range(0, 1))};
            endcase
         end else begin
            hdr = 8'($urandom);
         end
         send_item(hdr, data, i == n_items - 1,
                   i == n_items - 1 && $urandom_range(0, 9) == 0);
      end
   endtask

   task automatic test_random_descriptors();
      int unsigned stop_at;
      int unsigned chunk_end;
      stop_at = words_sent + 2000;
      while (words_sent < stop_at) begin
         case ($urandom_range(0, 5))
            0: set_lengths(8'd1, 8'd0);
            1: set_lengths(8'd255, 8'd255);
            2: set_lengths(8'd0, 8'($urandom));
            default: set_lengths(8'($urandom_range(1, 255)), 8'($urandom));
         endcase
         req_gaps_on   = ($urandom_range(0, 2) != 0);
         rsp_stalls_on = ($urandom_range(0, 2) != 0);
         chunk_end = words_sent + $urandom_range(100, 300);
         while (words_sent < chunk_end)
            send_random_descriptor();
      end
   endtask

   // Hold ready low for random stretches.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_stalls_on && $urandom_range(0, 99) < 25) begin
            rsp_ch.ready <= 1'b0;
            repeat (pick_delay() - 1) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_lengths.size() == 0) begin
            flag_mismatch("result with nothing pending, report_bytes", 0,
                          rsp_ch.report_bytes);
         end else begin
            want = expected_lengths.pop_front();
            if (rsp_ch.report_bytes !== want.report_bytes)
               flag_mismatch("report_bytes", want.report_bytes, rsp_ch.report_bytes);
            if (rsp_ch.report_bits !== want.report_bits)
               flag_mismatch("report_bits", want.report_bits, rsp_ch.report_bits);
            if (rsp_ch.truncated !== want.truncated)
               flag_mismatch("truncated", want.truncated, rsp_ch.truncated);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          csr_psel) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles == WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.desc_byte = '0;
      req_ch.last_byte = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_report_items();
      test_truncated_items();
      test_register_extremes();
      test_random_descriptors();

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
